// ===== src/lbs_pkg.sv =====
package lbs_pkg;

  localparam int MaxBackends = 4;
  localparam int NumSlots    = 4;
  localparam int SlotLimit   = (MaxBackends < NumSlots) ? MaxBackends : NumSlots;

  localparam int TotalW  = 3;
  localparam int ModeW   = 2;
  localparam int ProtoW  = 8;
  localparam int PortW   = 16;
  localparam int IpW     = 32;
  localparam int EntryW  = 49;
  localparam int IdxW    = 2;
  localparam int CountW  = 32;
  localparam int HealthBit = 48;
  localparam int CfgIdxW = 3;
  localparam int StepW   = 4;

  localparam logic [IpW-1:0]    HashC1   = 32'h85eb_ca6b;
  localparam logic [IpW-1:0]    HashC2   = 32'hc2b2_ae35;
  localparam logic [CountW-1:0] CountMax = 32'hFFFF_FFFF;

  localparam logic [CfgIdxW-1:0] RegTotal   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegProto   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPort    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEntry0  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegEntry1  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEntry2  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegEntry3  = 3'd7;

  localparam logic [ModeW-1:0] ModeRr   = 2'd0;
  localparam logic [ModeW-1:0] ModeLc   = 2'd1;
  localparam logic [ModeW-1:0] ModeHash = 2'd2;
  localparam logic [ModeW-1:0] ModeZero = 2'd3;

  localparam logic [StepW-1:0] StepIdle     = 4'd0;
  localparam logic [StepW-1:0] StepCheck    = 4'd1;
  localparam logic [StepW-1:0] StepModeRr   = 4'd2;
  localparam logic [StepW-1:0] StepModeLc   = 4'd3;
  localparam logic [StepW-1:0] StepModeZero = 4'd4;
  localparam logic [StepW-1:0] StepHash1    = 4'd5;
  localparam logic [StepW-1:0] StepHash2    = 4'd6;
  localparam logic [StepW-1:0] StepLoadHash = 4'd7;
  localparam logic [StepW-1:0] StepLoadRot  = 4'd8;
  localparam logic [StepW-1:0] StepMod      = 4'd9;
  localparam logic [StepW-1:0] StepCandMod  = 4'd10;
  localparam logic [StepW-1:0] StepLc       = 4'd11;
  localparam logic [StepW-1:0] StepResolve  = 4'd12;
  localparam logic [StepW-1:0] StepEmit     = 4'd13;

  typedef enum logic [3:0] {
    OpNop,
    OpLatch,
    OpHash1,
    OpHash2,
    OpLoadHash,
    OpLoadRot,
    OpModStep,
    OpCandMod,
    OpLcStep,
    OpResolve,
    OpEmit
  } op_e;

  typedef enum logic [3:0] {
    CondNever,
    CondAlways,
    CondIdle,
    CondMiss,
    CondRr,
    CondLc,
    CondZero,
    CondModMore,
    CondLcMore
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic             miss;
    logic [ModeW-1:0] mode;
    logic             mod_more;
    logic             lc_more;
  } stat_t;

  typedef struct packed {
    logic [TotalW-1:0]                total;
    logic [ModeW-1:0]                 mode;
    logic [ProtoW-1:0]                svc_proto;
    logic [PortW-1:0]                 svc_port;
    logic [NumSlots-1:0][EntryW-1:0]  entry;
  } cfg_t;

endpackage

// ===== src/lbs_sequencer.sv =====
module lbs_sequencer import lbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy,
  output logic  done_o
);

  logic [StepW-1:0] pc_q, pc_d;
  uword_t           uw;
  logic             take;

  always_comb begin
    case (pc_q)
      StepIdle:     uw = '{OpLatch,    CondIdle,    StepIdle};
      StepCheck:    uw = '{OpNop,      CondMiss,    StepEmit};
      StepModeRr:   uw = '{OpNop,      CondRr,      StepLoadRot};
      StepModeLc:   uw = '{OpNop,      CondLc,      StepLc};
      StepModeZero: uw = '{OpNop,      CondZero,    StepResolve};
      StepHash1:    uw = '{OpHash1,    CondNever,   StepIdle};
      StepHash2:    uw = '{OpHash2,    CondNever,   StepIdle};
      StepLoadHash: uw = '{OpLoadHash, CondAlways,  StepMod};
      StepLoadRot:  uw = '{OpLoadRot,  CondNever,   StepIdle};
      StepMod:      uw = '{OpModStep,  CondModMore, StepMod};
      StepCandMod:  uw = '{OpCandMod,  CondAlways,  StepResolve};
      StepLc:       uw = '{OpLcStep,   CondLcMore,  StepLc};
      StepResolve:  uw = '{OpResolve,  CondNever,   StepIdle};
      StepEmit:     uw = '{OpEmit,     CondAlways,  StepIdle};
      default:      uw = '{OpNop,      CondAlways,  StepIdle};
    endcase
  end

  always_comb begin
    case (uw.cond)
      CondNever:   take = 1'b0;
      CondAlways:  take = 1'b1;
      CondIdle:    take = !start;
      CondMiss:    take = stat_i.miss;
      CondRr:      take = (stat_i.mode == ModeRr);
      CondLc:      take = (stat_i.mode == ModeLc);
      CondZero:    take = (stat_i.mode == ModeZero);
      CondModMore: take = stat_i.mod_more;
      CondLcMore:  take = stat_i.lc_more;
      default:     take = 1'b1;
    endcase
  end

  assign pc_d        = take ? uw.target : pc_q + 4'd1;
  assign busy        = (pc_q != StepIdle);
  assign ctrl_o.op   = (pc_q == StepIdle && !start) ? OpNop : uw.op;
  assign done_o      = (uw.op == OpEmit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_accept_enters_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> pc_q == StepCheck)
    else $error("accepted item did not enter the check step");

  a_emit_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> pc_q == StepIdle && !done_o)
    else $error("result strobe not followed by idle");

endmodule

// ===== src/lbs_datapath.sv =====
module lbs_datapath import lbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  input  cfg_t                cfg_i,
  input  logic [ProtoW-1:0]   protocol_i,
  input  logic [PortW-1:0]    dst_port_i,
  input  logic [IpW-1:0]      source_ip_i,
  output stat_t               stat_o,
  output logic                found_o,
  output logic [IdxW-1:0]     target_idx_o,
  output logic [IpW-1:0]      target_ip_o,
  output logic [PortW-1:0]    target_port_o
);

  logic [ProtoW-1:0]  proto_q;
  logic [PortW-1:0]   port_q;
  logic [IpW-1:0]     src_q;
  logic [IpW-1:0]     h_q;
  logic [IpW-1:0]     div_q;
  logic [TotalW-1:0]  rem_q, rem_d;
  logic [1:0]         mod_cnt_q;
  logic [TotalW-1:0]  cand_q;
  logic [IdxW-1:0]    lc_i_q;
  logic               best_vld_q;
  logic [CountW-1:0]  best_q;
  logic [IpW-1:0]     rot_q;
  logic [NumSlots-1:0][CountW-1:0] cnt_q;

  logic               ok_q;
  logic [IdxW-1:0]    idx_q;
  logic [IpW-1:0]     ip_q;
  logic [PortW-1:0]   bport_q;

  logic [IpW-1:0]     mul_a, mul_b, mul_p;
  logic [IdxW-1:0]    cnt_addr;
  logic [CountW-1:0]  cnt_rd;
  logic               lc_take;
  logic [TotalW-1:0]  lc_next;

  logic [TotalW-1:0]  res_cand;
  logic               res_cand_ok;
  logic               res_ok;
  logic [IdxW-1:0]    res_idx;
  logic               res_inc;

  assign stat_o.miss     = (proto_q != cfg_i.svc_proto) || (port_q != cfg_i.svc_port) ||
                           (cfg_i.total == '0);
  assign stat_o.mode     = cfg_i.mode;
  assign stat_o.mod_more = (mod_cnt_q != 2'd3);
  assign lc_next         = {1'b0, lc_i_q} + 3'd1;
  assign stat_o.lc_more  = (lc_i_q != 2'd3) && (lc_next < cfg_i.total) &&
                           (lc_next < TotalW'(SlotLimit));

  assign mul_a = (ctrl_i.op == OpHash1) ? (src_q ^ (src_q >> 16)) : (h_q ^ (h_q >> 13));
  assign mul_b = (ctrl_i.op == OpHash1) ? HashC1 : HashC2;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    logic [TotalW:0]   r4;
    logic [TotalW-1:0] r;
    r = rem_q;
    for (int k = 0; k < 8; k++) begin
      r4 = {r, div_q[IpW-1-k]};
      if (r4 >= {1'b0, cfg_i.total}) begin
        r4 = r4 - {1'b0, cfg_i.total};
      end
      r = r4[TotalW-1:0];
    end
    rem_d = r;
  end

  always_comb begin
    res_cand    = (cand_q < cfg_i.total) ? cand_q : '0;
    res_cand_ok = (res_cand < TotalW'(SlotLimit)) && cfg_i.entry[res_cand[IdxW-1:0]][HealthBit];
    if (res_cand_ok) begin
      res_ok  = 1'b1;
      res_idx = res_cand[IdxW-1:0];
    end else if (res_cand != '0 && cfg_i.entry[0][HealthBit]) begin
      res_ok  = 1'b1;
      res_idx = '0;
    end else begin
      res_ok  = 1'b0;
      res_idx = '0;
    end
  end

  assign cnt_addr = (ctrl_i.op == OpLcStep) ? lc_i_q : res_idx;
  assign cnt_rd   = cnt_q[cnt_addr];
  assign lc_take  = ({1'b0, lc_i_q} < cfg_i.total) && ({1'b0, lc_i_q} < TotalW'(SlotLimit)) &&
                    cfg_i.entry[lc_i_q][HealthBit] && (!best_vld_q || cnt_rd < best_q);
  assign res_inc  = (cfg_i.mode == ModeLc) && res_ok && (cnt_rd != CountMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q      <= '0;
      cnt_q      <= '0;
      mod_cnt_q  <= '0;
      lc_i_q     <= '0;
      best_vld_q <= 1'b0;
      ok_q       <= 1'b0;
    end else begin
      case (ctrl_i.op)
        OpLatch: begin
          lc_i_q     <= '0;
          best_vld_q <= 1'b0;
          ok_q       <= 1'b0;
        end
        OpLoadHash: begin
          mod_cnt_q <= '0;
        end
        OpLoadRot: begin
          mod_cnt_q <= '0;
          rot_q     <= rot_q + 32'd1;
        end
        OpModStep: begin
          mod_cnt_q <= mod_cnt_q + 2'd1;
        end
        OpLcStep: begin
          lc_i_q <= lc_i_q + 2'd1;
          if (lc_take) begin
            best_vld_q <= 1'b1;
          end
        end
        OpResolve: begin
          ok_q <= res_ok;
          if (res_inc) begin
            cnt_q[res_idx] <= cnt_rd + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OpLatch: begin
        proto_q <= protocol_i;
        port_q  <= dst_port_i;
        src_q   <= source_ip_i;
        cand_q  <= '0;
        idx_q   <= '0;
        ip_q    <= '0;
        bport_q <= '0;
      end
      OpHash1, OpHash2: begin
        h_q <= mul_p;
      end
      OpLoadHash: begin
        div_q <= h_q ^ (h_q >> 16);
        rem_q <= '0;
      end
      OpLoadRot: begin
        div_q <= rot_q;
        rem_q <= '0;
      end
      OpModStep: begin
        rem_q <= rem_d;
        div_q <= div_q << 8;
      end
      OpCandMod: begin
        cand_q <= rem_q;
      end
      OpLcStep: begin
        if (lc_take) begin
          best_q <= cnt_rd;
          cand_q <= {1'b0, lc_i_q};
        end
      end
      OpResolve: begin
        idx_q   <= res_idx;
        ip_q    <= res_ok ? cfg_i.entry[res_idx][47:16] : '0;
        bport_q <= res_ok ? cfg_i.entry[res_idx][15:0] : '0;
      end
      default: begin
      end
    endcase
  end

  assign found_o       = ok_q;
  assign target_idx_o  = idx_q;
  assign target_ip_o   = ip_q;
  assign target_port_o = bport_q;

  a_rot_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op != OpLoadRot |=> $stable(rot_q))
    else $error("rotation counter moved outside its load step");

  a_lc_idx_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op != OpLcStep && ctrl_i.op != OpLatch |=> $stable(lc_i_q))
    else $error("scan index moved outside the scan");

  a_latch_clears_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == OpLatch |=> !ok_q)
    else $error("found flag not cleared by a new item");

endmodule

// ===== src/l4_backend_selector_top.sv =====
// Channel   Direction  Handshake                Payload
// input     in         start / busy             protocol_i, dst_port_i, source_ip_i
// result    out        done_o (one-cycle)       found_o, target_idx_o, target_ip_o,
//                                               target_port_o
// config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// An item runs a short microprogram: a service miss goes straight to done_o,
// always-zero resolves slot 0, least connections scans the backends, and round
// robin and address hash reduce the rotation counter or the shared-multiplier
// hash modulo total in the 8-bit-per-step loop. busy drops the cycle after done_o.
// Reset clears config, rotation counter and connection counts; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
module l4_backend_selector_top import lbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ProtoW-1:0]   protocol_i,
  input  logic [PortW-1:0]    dst_port_i,
  input  logic [IpW-1:0]      source_ip_i,
  output logic                done_o,
  output logic                found_o,
  output logic [IdxW-1:0]     target_idx_o,
  output logic [IpW-1:0]      target_ip_o,
  output logic [PortW-1:0]    target_port_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [EntryW-1:0]   cfg_wdata_i
);

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTotal:  cfg_q.total     <= cfg_wdata_i[TotalW-1:0];
        RegMode:   cfg_q.mode      <= cfg_wdata_i[ModeW-1:0];
        RegProto:  cfg_q.svc_proto <= cfg_wdata_i[ProtoW-1:0];
        RegPort:   cfg_q.svc_port  <= cfg_wdata_i[PortW-1:0];
        RegEntry0: cfg_q.entry[0]  <= cfg_wdata_i;
        RegEntry1: cfg_q.entry[1]  <= cfg_wdata_i;
        RegEntry2: cfg_q.entry[2]  <= cfg_wdata_i;
        RegEntry3: cfg_q.entry[3]  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  lbs_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy),
    .done_o (done_o)
  );

  lbs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .protocol_i    (protocol_i),
    .dst_port_i    (dst_port_i),
    .source_ip_i   (source_ip_i),
    .stat_o        (stat),
    .found_o       (found_o),
    .target_idx_o  (target_idx_o),
    .target_ip_o   (target_ip_o),
    .target_port_o (target_port_o)
  );

endmodule

// ===== dv/tb_l4_backend_selector_top.sv =====
`timescale 1ns / 1ps

module tb_l4_backend_selector_top;
  import lbs_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseCount = 20;
  localparam int PhaseItems = 100;

  typedef struct packed {
    logic             found;
    logic [IdxW-1:0]  index;
    logic [IpW-1:0]   ip;
    logic [PortW-1:0] port;
  } pick_t;

  class pick_scoreboard;
    logic [TotalW-1:0] total;
    logic [ModeW-1:0]  mode;
    logic [ProtoW-1:0] svc_proto;
    logic [PortW-1:0]  svc_port;
    logic [EntryW-1:0] entry [NumSlots];
    logic [IpW-1:0]    rotation;
    logic [CountW-1:0] conns [NumSlots];
    pick_t             picks_due [$];
    int unsigned       faults;

    function new();
      total = '0;
      mode = ModeRr;
      svc_proto = '0;
      svc_port = '0;
      rotation = '0;
      faults = 0;
      for (int i = 0; i < NumSlots; i++) begin
        entry[i] = '0;
        conns[i] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [EntryW-1:0] data);
      case (idx)
        RegTotal: total = data[TotalW-1:0];
        RegMode: mode = data[ModeW-1:0];
        RegProto: svc_proto = data[ProtoW-1:0];
        RegPort: svc_port = data[PortW-1:0];
        RegEntry0, RegEntry1, RegEntry2, RegEntry3: entry[idx - RegEntry0] = data;
        default: ;
      endcase
    endfunction

    function bit healthy(int i);
      if (i >= SlotLimit) return 1'b0;
      return entry[i][HealthBit];
    endfunction

    function logic [IpW-1:0] mix(logic [IpW-1:0] h);
      h = h ^ (h >> 16);
      h = h * HashC1;
      h = h ^ (h >> 13);
      h = h * HashC2;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function void note_flow(logic [ProtoW-1:0] proto, logic [PortW-1:0] port,
                            logic [IpW-1:0] src);
      pick_t       p;
      int          cand;
      bit          ok;
      logic [63:0] best;
      p = '0;
      ok = 1'b0;
      cand = 0;
      if (proto == svc_proto && port == svc_port && total != 0) begin
        case (mode)
          ModeRr: begin
            cand = rotation % total;
            rotation = rotation + 1;
          end
          ModeLc: begin
            best = '1;
            for (int i = 0; i < NumSlots && i < total; i++) begin
              if (healthy(i) && {32'b0, conns[i]} < best) begin
                best = {32'b0, conns[i]};
                cand = i;
              end
            end
          end
          ModeHash: cand = mix(src) % total;
          default: cand = 0;
        endcase
        if (cand >= total) cand = 0;
        if (healthy(cand)) begin
          ok = 1'b1;
        end else if (cand != 0 && healthy(0)) begin
          cand = 0;
          ok = 1'b1;
        end
        if (ok) begin
          if (mode == ModeLc && conns[cand] != CountMax) conns[cand] = conns[cand] + 1;
          p.found = 1'b1;
          p.index = cand[IdxW-1:0];
          p.ip = entry[cand][16 +: IpW];
          p.port = entry[cand][PortW-1:0];
        end
      end
      picks_due.push_back(p);
    endfunction

    function void check_pick(logic found, logic [IdxW-1:0] index, logic [IpW-1:0] ip,
                             logic [PortW-1:0] port);
      pick_t want;
      if (picks_due.size() == 0) begin
        $error("result with no selection pending");
        faults++;
        return;
      end
      want = picks_due.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, found);
        faults++;
      end
      if (index !== want.index) begin
        $error("target_idx: expected %0d, actual %0d", want.index, index);
        faults++;
      end
      if (ip !== want.ip) begin
        $error("target_ip: expected %h, actual %h", want.ip, ip);
        faults++;
      end
      if (port !== want.port) begin
        $error("target_port: expected %h, actual %h", want.port, port);
        faults++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [ProtoW-1:0]  protocol_i = '0;
  logic [PortW-1:0]   dst_port_i = '0;
  logic [IpW-1:0]     source_ip_i = '0;
  logic               done_o;
  logic               found_o;
  logic [IdxW-1:0]    target_idx_o;
  logic [IpW-1:0]     target_ip_o;
  logic [PortW-1:0]   target_port_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [EntryW-1:0]  cfg_wdata_i = '0;

  pick_scoreboard picks = new();
  int             stall_cycles = 0;

  l4_backend_selector_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .protocol_i(protocol_i),
    .dst_port_i(dst_port_i),
    .source_ip_i(source_ip_i),
    .done_o(done_o),
    .found_o(found_o),
    .target_idx_o(target_idx_o),
    .target_ip_o(target_ip_o),
    .target_port_o(target_port_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      picks.check_pick(found_o, target_idx_o, target_ip_o, target_port_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_flow(logic [ProtoW-1:0] proto, logic [PortW-1:0] port,
                           logic [IpW-1:0] src);
    @(negedge clk_i);
    start <= 1'b1;
    protocol_i <= proto;
    dst_port_i <= port;
    source_ip_i <= src;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    picks.note_flow(proto, port, src);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (picks.picks_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [EntryW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    picks.set_reg(idx, data);
  endtask

  task automatic load_service(logic [TotalW-1:0] total, logic [ModeW-1:0] mode,
                              logic [ProtoW-1:0] proto, logic [PortW-1:0] port,
                              logic [EntryW-1:0] ents [NumSlots]);
    settle();
    write_reg(RegTotal, EntryW'(total));
    write_reg(RegMode, EntryW'(mode));
    write_reg(RegProto, EntryW'(proto));
    write_reg(RegPort, EntryW'(port));
    write_reg(RegEntry0, ents[0]);
    write_reg(RegEntry1, ents[1]);
    write_reg(RegEntry2, ents[2]);
    write_reg(RegEntry3, ents[3]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [EntryW-1:0] rand_entry();
    logic [EntryW-1:0] e;
    int                r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    e = EntryW'({$urandom, $urandom});
    e[HealthBit] = ($urandom_range(0, 3) != 0);
    return e;
  endfunction

  logic [EntryW-1:0] ents [NumSlots];
  logic [TotalW-1:0] r_total;
  logic [ModeW-1:0]  r_mode;
  logic [ProtoW-1:0] r_proto;
  logic [PortW-1:0]  r_port;
  bit                quiet;
  int                pause_at;
  int                pick;

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero backend total straight out of reset
    send_flow(8'd0, 16'd0, 32'd0);

    ents = '{{1'b1, 32'hC0A8_0001, 16'd8080}, {1'b1, 32'hC0A8_0002, 16'd8081},
             {1'b1, 32'hC0A8_0003, 16'd8082}, {1'b1, 32'hC0A8_0004, 16'd8083}};
    load_service(3'd4, ModeRr, 8'd6, 16'd80, ents);
    repeat (5) send_flow(8'd6, 16'd80, $urandom);
    send_flow(8'd7, 16'd80, 32'd0);
    send_flow(8'd6, 16'd81, 32'd0);

    // total beyond the existing slots, one unhealthy slot
    ents[2][HealthBit] = 1'b0;
    load_service(3'd7, ModeRr, 8'hFF, 16'hFFFF, ents);
    repeat (7) send_flow(8'hFF, 16'hFFFF, $urandom);

    ents[0][HealthBit] = 1'b0;
    ents[2][HealthBit] = 1'b1;
    ents[3] = '1;
    load_service(3'd3, ModeLc, 8'd17, 16'd53, ents);
    repeat (4) send_flow(8'd17, 16'd53, $urandom);

    ents = '{'1, {1'b0, 32'h0A00_0001, 16'd1}, '0, {1'b1, 32'h0A00_0003, 16'd3}};
    load_service(3'd4, ModeHash, 8'd0, 16'd0, ents);
    send_flow(8'd0, 16'd0, 32'h0000_0000);
    send_flow(8'd0, 16'd0, 32'hFFFF_FFFF);
    send_flow(8'd0, 16'd0, 32'h8000_0000);
    send_flow(8'd0, 16'd0, 32'h0000_0001);

    ents[0][HealthBit] = 1'b0;
    load_service(3'd2, ModeZero, 8'd0, 16'd0, ents);
    repeat (2) send_flow(8'd0, 16'd0, $urandom);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) r_total = 3'd0;
      else if (pick == 1) r_total = TotalW'($urandom_range(5, 7));
      else r_total = TotalW'($urandom_range(1, 4));
      r_mode = ModeW'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) r_proto = $urandom_range(0, 1) ? '1 : '0;
      else r_proto = ProtoW'($urandom);
      if ($urandom_range(0, 7) == 0) r_port = $urandom_range(0, 1) ? '1 : '0;
      else r_port = PortW'($urandom);
      for (int i = 0; i < NumSlots; i++) ents[i] = rand_entry();
      load_service(r_total, r_mode, r_proto, r_port, ents);
      quiet = ($urandom_range(0, 3) == 0);
      pause_at = $urandom_range(0, PhaseItems - 1);
      for (int k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) send_flow(r_proto, r_port, $urandom);
        else if (pick < 88)
          send_flow(r_proto ^ ProtoW'(1 << $urandom_range(0, ProtoW - 1)), r_port, $urandom);
        else if (pick < 95)
          send_flow(r_proto, r_port ^ PortW'(1 << $urandom_range(0, PortW - 1)), $urandom);
        else send_flow(ProtoW'($urandom), PortW'($urandom), $urandom);
        if (k == pause_at) settle();
        else if (!quiet) hold_off(gap_len());
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (picks.faults == 0 && picks.picks_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== l4_backend_selector_top.f =====
src/lbs_pkg.sv
src/lbs_sequencer.sv
src/lbs_datapath.sv
src/l4_backend_selector_top.sv
dv/tb_l4_backend_selector_top.sv
